>>> src/psmt_pkg.sv
`timescale 1ns / 1ps
// Package for the pulse-sequence match table: sizes, codes, the token that
// walks the chain of slot cells, and the pattern mask helper. No dependencies.
package psmt_pkg;

  localparam int TableDepth   = 16;
  localparam int MaxPulses    = 8;
  localparam int PulsePosBits = 8;
  localparam int SlotW        = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CountW       = $clog2(TableDepth + 1);
  localparam int LimitW       = 5;
  localparam int ScalW        = 58;
  localparam int PatW         = 64;
  localparam int PcntW        = 4;

  localparam logic [1:0] ModeAdd    = 2'd0;
  localparam logic [1:0] ModeLookup = 2'd1;
  localparam logic [1:0] ModeRemove = 2'd2;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusMiss  = 2'd2;
  localparam logic [1:0] StatusEmpty = 2'd3;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_LOOKUP,
    OP_REMOVE,
    OP_NONE
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              valid;
    op_e               op;
    logic [ScalW-1:0]  scal;
    logic [PatW-1:0]   pat;
    logic [PatW-1:0]   mask;
    logic [SlotW-1:0]  pos;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] count;
    logic              hit;
    logic [SlotW-1:0]  hit_idx;
  } tok_t;

  function automatic logic [PatW-1:0] pattern_mask(input logic [PcntW-1:0] pcnt);
    logic [PatW-1:0] m;
    m = '0;
    for (int k = 0; k < MaxPulses; k++) begin
      if (k < int'(pcnt) && (k + 1) * PulsePosBits <= PatW) begin
        m[k*PulsePosBits +: PulsePosBits] = '1;
      end
    end
    return m;
  endfunction

endpackage

>>> src/psmt_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the pulse-sequence match table:
// item input, result output and limit register write. Uses psmt_pkg.
interface psmt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [9:0]  range_count;
  logic [11:0] first_range;
  logic [9:0]  range_spacing;
  logic [3:0]  pulse_count;
  logic [15:0] pulse_increment;
  logic [5:0]  baud_count;
  logic [63:0] pulse_pattern;
  logic [3:0]  slot;
  modport source (output valid, mode, range_count, first_range, range_spacing,
                  pulse_count, pulse_increment, baud_count, pulse_pattern, slot,
                  input ready);
  modport sink (input valid, mode, range_count, first_range, range_spacing,
                pulse_count, pulse_increment, baud_count, pulse_pattern, slot,
                output ready);
endinterface

interface psmt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] slot_index;
  modport source (output valid, status, slot_index, input ready);
  modport sink (input valid, status, slot_index, output ready);
endinterface

interface psmt_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [psmt_pkg::LimitW-1:0] table_limit;
  modport source (output valid, table_limit, input ready);
  modport sink (input valid, table_limit, output ready);
endinterface

>>> src/psmt_cell.sv
`timescale 1ns / 1ps
// One table slot: holds the descriptor and active mark, acts on the token
// passing through and hands it on in the next cycle. Uses psmt_pkg.
module psmt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  psmt_pkg::tok_t tok_i,
  output psmt_pkg::tok_t tok_o
);

  logic                         active_q, active_d;
  logic [psmt_pkg::ScalW-1:0]   scal_q;
  logic [psmt_pkg::PatW-1:0]    pat_q;
  logic                         wr_en;
  psmt_pkg::tok_t               tok_q, tok_d;
  logic                         below_count, at_or_below_count, match;

  always_comb begin
    below_count       = {1'b0, tok_i.pos} < {1'b0, tok_i.count};
    at_or_below_count = {1'b0, tok_i.pos} <= {1'b0, tok_i.count};
    match = active_q && (scal_q == tok_i.scal) && (((pat_q ^ tok_i.pat) & tok_i.mask) == '0);
    tok_d     = tok_i;
    tok_d.pos = tok_i.pos + 1'b1;
    active_d  = active_q;
    wr_en     = 1'b0;
    if (tok_i.valid) begin
      case (tok_i.op)
        psmt_pkg::OP_ADD: begin
          if (!tok_i.hit && !active_q && at_or_below_count) begin
            wr_en         = 1'b1;
            active_d      = 1'b1;
            tok_d.hit     = 1'b1;
            tok_d.hit_idx = tok_i.pos;
          end
        end
        psmt_pkg::OP_LOOKUP: begin
          if (match && below_count) begin
            tok_d.hit     = 1'b1;
            tok_d.hit_idx = tok_i.pos;
          end
        end
        psmt_pkg::OP_REMOVE: begin
          if (tok_i.slot == tok_i.pos) active_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      tok_q    <= '0;
    end else begin
      active_q <= active_d;
      tok_q    <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      scal_q <= tok_i.scal;
      pat_q  <= tok_i.pat;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> src/pulse_sequence_match_table.sv
`timescale 1ns / 1ps
// Pulse-sequence match table top level: a chain of TableDepth slot cells,
// the high-water count, the limit register and the result register.
// Depends on psmt_pkg, psmt_if and psmt_cell.
//
// Channels: in_i takes one operation per beat (add, lookup, remove),
// out_o returns one beat of status and slot index per operation, and
// cfg_i writes table_limit (always ready, reset value 16).
// Each operation launches a token into slot cell 0; it moves one cell per
// cycle and is taken from the last cell. The result is captured in the
// result register as the token leaves, then moves into the output register
// and raises out_o.valid once the output is free (not valid, or taken);
// a new item is taken only after that. One item is in flight at a time, so
// the walk along the cell chain sets how often a new item can be taken.
// Reset clears all active marks, the high-water count and the output
// valid; descriptor storage is not cleared. If the receiver stalls, the
// result holds on out_o and a finished next result waits in the result
// holding register while in_i.ready stays low.
module pulse_sequence_match_table (
  input  logic clk_i,
  input  logic rst_ni,
  psmt_in_if.sink    in_i,
  psmt_out_if.source out_o,
  psmt_cfg_if.sink   cfg_i
);

  localparam int Depth = psmt_pkg::TableDepth;

  psmt_pkg::state_e                state_q, state_d;
  logic [psmt_pkg::LimitW-1:0]     limit_q;
  logic [psmt_pkg::CountW-1:0]     count_q, count_d;
  logic [psmt_pkg::CountW-1:0]     eff_limit;
  logic [1:0]                      res_status_q, res_status_d;
  logic [psmt_pkg::SlotW-1:0]      res_idx_q, res_idx_d;
  logic                            out_valid_q, out_valid_d;
  logic [1:0]                      out_status_q;
  logic [psmt_pkg::SlotW-1:0]      out_idx_q;
  logic                            in_fire, out_load;
  psmt_pkg::tok_t                  chain [Depth+1];
  psmt_pkg::tok_t                  launch, exit_tok;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= psmt_pkg::LimitW'(Depth);
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.table_limit;
    end
  end

  assign eff_limit = ({1'b0, limit_q} > (psmt_pkg::LimitW + 1)'(Depth)) ?
                     psmt_pkg::CountW'(Depth) : psmt_pkg::CountW'(limit_q);

  assign in_i.ready = (state_q == psmt_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  always_comb begin
    launch         = '0;
    launch.valid   = in_fire;
    launch.scal    = {in_i.range_count, in_i.first_range, in_i.range_spacing,
                      in_i.pulse_count, in_i.pulse_increment, in_i.baud_count};
    launch.pat     = in_i.pulse_pattern;
    launch.mask    = psmt_pkg::pattern_mask(in_i.pulse_count);
    launch.slot    = psmt_pkg::SlotW'(in_i.slot);
    launch.count   = count_q;
    case (in_i.mode)
      psmt_pkg::ModeAdd:
        launch.op = (count_q >= eff_limit) ? psmt_pkg::OP_NONE : psmt_pkg::OP_ADD;
      psmt_pkg::ModeLookup:
        launch.op = (count_q == '0) ? psmt_pkg::OP_NONE : psmt_pkg::OP_LOOKUP;
      psmt_pkg::ModeRemove:
        launch.op = (count_q == '0) ? psmt_pkg::OP_NONE : psmt_pkg::OP_REMOVE;
      default:
        launch.op = psmt_pkg::OP_NONE;
    endcase
  end

  // refused operations still walk the chain; their status is decided here
  logic [1:0] pre_status_q, pre_status_d;
  always_comb begin
    case (in_i.mode)
      psmt_pkg::ModeAdd:    pre_status_d = psmt_pkg::StatusFull;
      psmt_pkg::ModeLookup: pre_status_d = psmt_pkg::StatusEmpty;
      psmt_pkg::ModeRemove: pre_status_d = psmt_pkg::StatusEmpty;
      default:              pre_status_d = psmt_pkg::StatusMiss;
    endcase
  end

  assign chain[0] = launch;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    psmt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
  end

  assign exit_tok = chain[Depth];

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    out_valid_d  = out_valid_q;
    out_load     = 1'b0;
    if (out_valid_q && out_o.ready) out_valid_d = 1'b0;
    case (state_q)
      psmt_pkg::ST_IDLE: begin
        if (in_fire) state_d = psmt_pkg::ST_RUN;
      end
      psmt_pkg::ST_RUN: begin
        if (exit_tok.valid) begin
          state_d = psmt_pkg::ST_DONE;
          case (exit_tok.op)
            psmt_pkg::OP_ADD: begin
              res_status_d = psmt_pkg::StatusOk;
              res_idx_d    = exit_tok.hit_idx;
              if ({1'b0, exit_tok.hit_idx} == count_q) count_d = count_q + 1'b1;
            end
            psmt_pkg::OP_LOOKUP: begin
              res_status_d = exit_tok.hit ? psmt_pkg::StatusOk : psmt_pkg::StatusMiss;
              res_idx_d    = exit_tok.hit ? exit_tok.hit_idx : '0;
            end
            psmt_pkg::OP_REMOVE: begin
              res_status_d = psmt_pkg::StatusOk;
              res_idx_d    = exit_tok.slot;
              if ({1'b0, exit_tok.slot} + 1'b1 == count_q) count_d = count_q - 1'b1;
            end
            default: begin
              res_status_d = pre_status_q;
              res_idx_d    = '0;
            end
          endcase
        end
      end
      psmt_pkg::ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = psmt_pkg::ST_IDLE;
        end
      end
      default: state_d = psmt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psmt_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    if (in_fire) pre_status_q <= pre_status_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_idx_q    <= res_idx_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.slot_index = 4'(out_idx_q);

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for pulse_sequence_match_table: runs add, lookup and remove beats against
// a cycle-free table predictor across several limit settings and idle/stall phases.
// Depends on psmt_pkg, psmt_if and the block's RTL.
module testbench;
  import psmt_pkg::*;

  localparam logic [1:0] ModeUnused = 2'd3;
  localparam int unsigned StallLimit = 4000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  range_count;
    logic [11:0] first_range;
    logic [9:0]  range_spacing;
    logic [3:0]  pulse_count;
    logic [15:0] pulse_increment;
    logic [5:0]  baud_count;
    logic [63:0] pulse_pattern;
    logic [3:0]  slot;
  } op_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] slot_index;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  psmt_in_if  in_if ();
  psmt_out_if out_if ();
  psmt_cfg_if cfg_if ();

  pulse_sequence_match_table u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  op_item_t    op_pending [$];
  verdict_t    verdict_q [$];
  op_item_t    cur_op;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  int unsigned n_fail;
  int unsigned n_ops;
  int unsigned n_by_status [4];
  int unsigned idle_cycles;

  // predictor state
  logic [ScalW-1:0] tbl_scal [TableDepth];
  logic [PatW-1:0]  tbl_pat [TableDepth];
  logic             tbl_live [TableDepth];
  int unsigned      hw_count;
  int unsigned      limit_reg;

  function automatic verdict_t table_apply(op_item_t it);
    verdict_t         v;
    logic [ScalW-1:0] key;
    int unsigned      lim;
    int unsigned      npul;
    int unsigned      i;
    bit               found;
    bit               same;
    key = {it.range_count, it.first_range, it.range_spacing, it.pulse_count,
           it.pulse_increment, it.baud_count};
    v.status = StatusMiss;
    v.slot_index = '0;
    lim = (limit_reg > TableDepth) ? TableDepth : limit_reg;
    npul = (it.pulse_count > MaxPulses) ? MaxPulses : it.pulse_count;
    case (it.mode)
      ModeAdd: begin
        if (hw_count >= lim) begin
          v.status = StatusFull;
        end else begin
          i = 0;
          while (i < hw_count && tbl_live[i]) i++;
          tbl_live[i] = 1'b1;
          tbl_scal[i] = key;
          tbl_pat[i] = it.pulse_pattern;
          if (i == hw_count) hw_count++;
          v.status = StatusOk;
          v.slot_index = i[3:0];
        end
      end
      ModeLookup: begin
        if (hw_count == 0) begin
          v.status = StatusEmpty;
        end else begin
          i = hw_count;
          found = 1'b0;
          while (i > 0 && !found) begin
            i--;
            if (tbl_live[i] && tbl_scal[i] == key) begin
              same = 1'b1;
              for (int k = 0; k < npul; k++) begin
                if (tbl_pat[i][k*PulsePosBits +: PulsePosBits] !=
                    it.pulse_pattern[k*PulsePosBits +: PulsePosBits]) same = 1'b0;
              end
              if (same) begin
                found = 1'b1;
                v.status = StatusOk;
                v.slot_index = i[3:0];
              end
            end
          end
        end
      end
      ModeRemove: begin
        if (hw_count == 0) begin
          v.status = StatusEmpty;
        end else begin
          tbl_live[it.slot] = 1'b0;
          if (int'(it.slot) + 1 == hw_count) hw_count--;
          v.status = StatusOk;
          v.slot_index = it.slot;
        end
      end
      default: ;
    endcase
    return v;
  endfunction

  function automatic op_item_t fresh_key();
    op_item_t k;
    k.mode = ModeAdd;
    k.range_count = 10'($urandom);
    k.first_range = 12'($urandom);
    k.range_spacing = 10'($urandom);
    k.pulse_count = ($urandom_range(99) < 85) ? 4'($urandom_range(8)) : 4'($urandom_range(15, 9));
    k.pulse_increment = 16'($urandom);
    k.baud_count = 6'($urandom);
    k.pulse_pattern = {$urandom, $urandom};
    k.slot = 4'($urandom);
    return k;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // driver: one beat presented at a time, prediction taken at acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        verdict_q.push_back(table_apply(cur_op));
        n_ops++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (op_pending.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_op = op_pending.pop_front();
          in_if.valid           <= 1'b1;
          in_if.mode            <= cur_op.mode;
          in_if.range_count     <= cur_op.range_count;
          in_if.first_range     <= cur_op.first_range;
          in_if.range_spacing   <= cur_op.range_spacing;
          in_if.pulse_count     <= cur_op.pulse_count;
          in_if.pulse_increment <= cur_op.pulse_increment;
          in_if.baud_count      <= cur_op.baud_count;
          in_if.pulse_pattern   <= cur_op.pulse_pattern;
          in_if.slot            <= cur_op.slot;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (verdict_q.size() == 0) begin
          $error("result beat with nothing expected: status %0d slot_index %0d",
                 out_if.status, out_if.slot_index);
          n_fail++;
        end else begin
          want = verdict_q.pop_front();
          n_by_status[want.status]++;
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            n_fail++;
          end
          if (out_if.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, out_if.slot_index);
            n_fail++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no beat for %0d cycles", StallLimit);
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_op(input op_item_t it);
    op_pending.push_back(it);
  endtask

  task automatic drain();
    while (op_pending.size() != 0 || in_if.valid || verdict_q.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] v);
    @(posedge clk_i);
    cfg_if.valid       <= 1'b1;
    cfg_if.table_limit <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    limit_reg = v;
  endtask

  task automatic queue_random(input int unsigned n, input int unsigned lim);
    op_item_t    pool [6];
    op_item_t    it;
    int unsigned r;
    int unsigned span;
    span = (lim == 0) ? 1 : ((lim > TableDepth) ? TableDepth : lim);
    foreach (pool[j]) pool[j] = fresh_key();
    for (int unsigned n_done = 0; n_done < n; n_done++) begin
      r = $urandom_range(99);
      if (r < 40) begin
        it = ($urandom_range(99) < 80) ? pool[$urandom_range(5)] : fresh_key();
        it.slot = 4'($urandom);
        it.mode = ModeAdd;
      end else if (r < 80) begin
        it = pool[$urandom_range(5)];
        r = $urandom_range(99);
        if (r < 15) begin
          it = fresh_key();
        end else if (r < 40) begin
          case ($urandom_range(6))
            0: it.range_count[$urandom_range(9)] ^= 1'b1;
            1: it.first_range[$urandom_range(11)] ^= 1'b1;
            2: it.range_spacing[$urandom_range(9)] ^= 1'b1;
            3: it.pulse_count[$urandom_range(3)] ^= 1'b1;
            4: it.pulse_increment[$urandom_range(15)] ^= 1'b1;
            5: it.baud_count[$urandom_range(5)] ^= 1'b1;
            default: it.pulse_pattern[$urandom_range(63)] ^= 1'b1;
          endcase
        end
        // bytes past the pulse count must not affect the match
        for (int k = 0; k < MaxPulses; k++) begin
          if (k >= it.pulse_count) it.pulse_pattern[k*PulsePosBits +: PulsePosBits] = 8'($urandom);
        end
        it.slot = 4'($urandom);
        it.mode = ModeLookup;
      end else if (r < 97) begin
        it = fresh_key();
        it.slot = ($urandom_range(99) < 85) ? 4'($urandom_range(span - 1)) : 4'($urandom);
        it.mode = ModeRemove;
      end else begin
        it = fresh_key();
        it.mode = ModeUnused;
      end
      push_op(it);
    end
  endtask

  initial begin
    op_item_t k0, k1, k2, k3, it;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.mode = '0;
    in_if.range_count = '0;
    in_if.first_range = '0;
    in_if.range_spacing = '0;
    in_if.pulse_count = '0;
    in_if.pulse_increment = '0;
    in_if.baud_count = '0;
    in_if.pulse_pattern = '0;
    in_if.slot = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.table_limit = '0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    n_fail = 0;
    n_ops = 0;
    idle_cycles = 0;
    foreach (n_by_status[j]) n_by_status[j] = 0;
    foreach (tbl_live[j]) begin
      tbl_live[j] = 1'b0;
      tbl_scal[j] = '0;
      tbl_pat[j] = '0;
    end
    hw_count = 0;
    limit_reg = 16;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_limit(5'd16);
    k0 = '0;
    k1 = '1;
    k1.mode = ModeAdd;
    k2 = fresh_key();
    k2.pulse_count = 4'd3;
    k3 = fresh_key();
    it = fresh_key();
    it.mode = ModeLookup;
    push_op(it);
    it.mode = ModeRemove;
    it.slot = 4'd0;
    push_op(it);
    it.mode = ModeUnused;
    push_op(it);
    push_op(k0);
    push_op(k1);
    push_op(k2);
    it = k0;
    it.mode = ModeLookup;
    push_op(it);
    it.pulse_pattern = {$urandom, $urandom};
    push_op(it);
    it = k1;
    it.mode = ModeLookup;
    push_op(it);
    it.pulse_pattern[63] = 1'b0;
    push_op(it);
    it = k2;
    it.mode = ModeLookup;
    it.range_spacing[0] = ~it.range_spacing[0];
    push_op(it);
    it = k2;
    it.mode = ModeLookup;
    it.pulse_pattern[63:24] = ~k2.pulse_pattern[63:24];
    push_op(it);
    push_op(k2);
    it = k2;
    it.mode = ModeLookup;
    push_op(it);
    it.mode = ModeRemove;
    it.slot = 4'd1;
    push_op(it);
    it = k1;
    it.mode = ModeLookup;
    push_op(it);
    push_op(k3);
    it = k3;
    it.mode = ModeLookup;
    push_op(it);
    it.mode = ModeRemove;
    it.slot = 4'd3;
    push_op(it);
    it.slot = 4'd9;
    push_op(it);
    it.slot = 4'd2;
    push_op(it);
    it = k2;
    it.mode = ModeLookup;
    push_op(it);
    drain();

    queue_random(400, 16);
    drain();

    write_limit(5'd0);
    src_idle_pct = 86;
    snk_stall_pct = 0;
    queue_random(100, 0);
    drain();

    write_limit(5'd1);
    src_idle_pct = 0;
    snk_stall_pct = 86;
    queue_random(250, 1);
    drain();

    write_limit(5'd31);
    src_idle_pct = 36;
    snk_stall_pct = 36;
    queue_random(400, 31);
    drain();

    it.slot = 4'($urandom_range(15, 2));
    write_limit({1'b0, it.slot});
    src_idle_pct = 86;
    snk_stall_pct = 0;
    queue_random(300, it.slot);
    drain();

    write_limit(5'd16);
    src_idle_pct = 0;
    snk_stall_pct = 86;
    queue_random(400, 16);
    drain();

    if (verdict_q.size() != 0) begin
      $error("%0d expected results never arrived", verdict_q.size());
      n_fail++;
    end
    $display("ran %0d operations over limits 16, 0, 1, 31, mid and 16 with idle and stall phases",
             n_ops);
    $display("results: %0d ok, %0d full, %0d no match, %0d empty",
             n_by_status[StatusOk], n_by_status[StatusFull], n_by_status[StatusMiss],
             n_by_status[StatusEmpty]);
    if (n_fail == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
